// ===== hw/rtl/generational_segment_table_assert.svh =====
`ifndef GENERATIONAL_SEGMENT_TABLE_ASSERT_SVH
`define GENERATIONAL_SEGMENT_TABLE_ASSERT_SVH
// assertion helpers
`define GST_ASSERT(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define GST_ASSERT_NR(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`endif

// ===== hw/rtl/gst_pkg.sv =====
package gst_pkg;
	localparam int SLOTS_DEF = 32;
	localparam int SLOT_BITS_DEF = 10;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam int MAX_PAGES_DEF = 4096;
	localparam logic [1:0] REQ_OPEN = 2'd0;
	localparam logic [1:0] REQ_DESTROY = 2'd1;
	localparam logic [1:0] REQ_ABANDON = 2'd2;
	localparam logic [1:0] REQ_QUERY = 2'd3;
	localparam logic [31:0] PUBLIC_RESET = 32'd1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] seg_key;
		logic [31:0] byte_count;
		logic [31:0] user_id;
		logic [31:0] seg_flags;
		logic [31:0] proc_id;
		logic signed [31:0] handle;
		logic        alloc_ok;
	} req_t;

	typedef struct packed {
		logic        success;
		logic signed [31:0] handle_out;
		logic        may_access;
		logic [31:0] size_out;
		logic [12:0] pages_out;
		logic [31:0] owner_out;
		logic [5:0]  freed_count;
	} rsp_t;

	// front-end classification carried with the request
	typedef struct packed {
		req_t        req;
		logic        early_fail;
		logic [12:0] pages;
	} cmd_t;
endpackage

// ===== hw/rtl/gst_if.sv =====
interface gst_req_if;
	gst_pkg::req_t payload;
	logic valid;
	logic ready;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface gst_rsp_if;
	gst_pkg::rsp_t payload;
	logic valid;
	logic ready;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/gst_ram.sv =====
module gst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/gst_front.sv =====
module gst_front #(
	parameter int PAGE_BYTES = gst_pkg::PAGE_BYTES_DEF,
	parameter int MAX_PAGES = gst_pkg::MAX_PAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	gst_req_if.sink in_ch,
	output logic q_valid,
	input  logic q_ready,
	output gst_pkg::cmd_t q_cmd
);
	localparam int PB = $clog2(PAGE_BYTES);
	logic [32:0] pg_full;
	logic big;
	logic big_fail;
	gst_pkg::cmd_t c;
	logic [1:0] cnt_q;
	gst_pkg::cmd_t fifo_q [2];
	logic rd_q, wr_q;

	// ceil(bytes/page); PAGE_BYTES is a power of two
	assign pg_full = ({1'b0, in_ch.payload.byte_count} + 33'(PAGE_BYTES - 1)) >> PB;
	assign big = pg_full > 33'(MAX_PAGES);
	assign big_fail = (in_ch.payload.byte_count == 32'd0) || big;
	always_comb begin
		c.req = in_ch.payload;
		// size check matters only when no key match; zero pages marks a bad size
		c.pages = big_fail ? 13'd0 : pg_full[12:0];
		c.early_fail = (in_ch.payload.req_type == gst_pkg::REQ_OPEN) &&
			(in_ch.payload.seg_key == 32'd0);
	end

	assign in_ch.ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_cmd = fifo_q[rd_q];
	wire push = in_ch.valid && in_ch.ready;
	wire pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= c;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== hw/rtl/gst_back.sv =====
module gst_back #(
	parameter int SLOTS = gst_pkg::SLOTS_DEF,
	parameter int SLOT_BITS = gst_pkg::SLOT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [31:0] public_mask,
	input  logic q_valid,
	output logic q_ready,
	input  gst_pkg::cmd_t q_cmd,
	gst_rsp_if.source out_ch
);
	localparam int AW = $clog2(SLOTS > 1 ? SLOTS : 2);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int RW = 32 * 6 + 13;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_SCAN = 3'd1, ST_RD = 3'd2,
		ST_CHK = 3'd3, ST_DONE = 3'd4;

	logic [2:0] st_q;
	logic [SLOTS-1:0] used_q;
	logic [31:0] ngen_q;
	gst_pkg::cmd_t cmd_q;
	logic [AW:0] idx_q;
	logic [CW-1:0] n_q;
	logic match_q;
	logic [AW-1:0] msl_q, free_q;
	logic free_v_q;
	gst_pkg::rsp_t rsp_q, rsp_n;
	logic ov_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [RW-1:0] wdata, rdata;
	gst_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata));

	// fields: gen, key, uid, pid, bytes, flags, pages
	wire [31:0] r_gen = rdata[RW-1 -: 32];
	wire [31:0] r_key = rdata[RW-33 -: 32];
	wire [31:0] r_uid = rdata[RW-65 -: 32];
	wire [31:0] r_pid = rdata[RW-97 -: 32];
	wire [31:0] r_bytes = rdata[RW-129 -: 32];
	wire [31:0] r_flags = rdata[RW-161 -: 32];
	wire [12:0] r_pages = rdata[12:0];

	gst_pkg::req_t rq;
	assign rq = cmd_q.req;
	wire [AW-1:0] prev = idx_q[AW-1:0] - AW'(1);
	wire [31:0] hu = rq.handle;
	wire [AW-1:0] hslot = hu[AW-1:0];
	wire h_ok_fmt = !hu[31] && (32'(hu[SLOT_BITS-1:0]) < 32'(SLOTS));
	wire [31:0] hgen = hu >> SLOT_BITS;
	wire [31:0] packed_h = (r_gen << SLOT_BITS) | 32'(msl_q);
	wire gen_fits = (r_gen >> (31 - SLOT_BITS)) == 32'd0;
	wire allow = (rq.user_id == 32'd0) || (rq.user_id == r_uid) ||
		((r_flags & public_mask) != 32'd0);

	assign q_ready = st_q == ST_IDLE && !ov_q;
	assign out_ch.valid = ov_q;
	assign out_ch.payload = rsp_q;
	wire scan_hit = st_q == ST_SCAN && idx_q != '0 && used_q[prev];

	always_comb begin
		we = 1'b0; waddr = free_q; wdata = '0;
		raddr = idx_q[AW-1:0];
		if (st_q == ST_IDLE) raddr = q_cmd.req.handle[AW-1:0];
		if (st_q == ST_RD) raddr = msl_q;
		if (st_q == ST_SCAN && rq.req_type == gst_pkg::REQ_OPEN && !cmd_q.early_fail &&
			idx_q == (AW+1)'(SLOTS) && !match_q && !(scan_hit && r_key == rq.seg_key)
			&& free_v_q && cmd_q.pages != '0) begin
			we = 1'b1;
			wdata = {ngen_q, rq.seg_key, rq.user_id, rq.proc_id, rq.byte_count,
				rq.seg_flags, rq.alloc_ok ? cmd_q.pages : 13'd0};
		end
	end

	always_comb begin
		rsp_n = '0;
		rsp_n.handle_out = -32'sd1;
		if (st_q == ST_SCAN) begin
			if (rq.req_type == gst_pkg::REQ_ABANDON) begin
				rsp_n.success = 1'b1;
				rsp_n.freed_count = 6'(n_q) + 6'(used_q[prev] && r_pid == rq.proc_id);
			end else if (we && rq.alloc_ok) begin
				rsp_n.success = 1'b1;
				rsp_n.handle_out = (ngen_q << SLOT_BITS) | 32'(free_q);
			end
		end else if (rq.req_type == gst_pkg::REQ_OPEN) begin
			if (gen_fits && allow && r_pages != '0) begin
				rsp_n.success = 1'b1; rsp_n.handle_out = packed_h;
			end
		end else if (h_ok_fmt && used_q[hslot] && r_gen == hgen) begin
			if (rq.req_type == gst_pkg::REQ_DESTROY) begin
				if (rq.user_id == 32'd0 || rq.user_id == r_uid) rsp_n.success = 1'b1;
			end else begin
				rsp_n.success = 1'b1; rsp_n.may_access = allow;
				rsp_n.size_out = r_bytes; rsp_n.pages_out = r_pages;
				rsp_n.owner_out = r_uid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid) cmd_q <= q_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; used_q <= '0; ngen_q <= 32'd1; ov_q <= 1'b0;
			idx_q <= '0; n_q <= '0; match_q <= 1'b0; msl_q <= '0;
			free_q <= '0; free_v_q <= 1'b0; rsp_q <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready) ov_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (q_valid && !ov_q) begin
					idx_q <= '0; n_q <= '0; match_q <= 1'b0; free_v_q <= 1'b0;
					st_q <= (q_cmd.req.req_type == gst_pkg::REQ_OPEN ||
						q_cmd.req.req_type == gst_pkg::REQ_ABANDON) ? ST_SCAN : ST_CHK;
				end
				ST_SCAN: begin
					if (idx_q != '0) begin
						if (!used_q[prev] && !free_v_q) begin
							free_v_q <= 1'b1; free_q <= prev;
						end
						if (used_q[prev] && rq.req_type == gst_pkg::REQ_ABANDON &&
							r_pid == rq.proc_id) begin
							used_q[prev] <= 1'b0; n_q <= n_q + CW'(1);
						end
						if (used_q[prev] && rq.req_type == gst_pkg::REQ_OPEN &&
							!match_q && r_key == rq.seg_key) begin
							match_q <= 1'b1; msl_q <= prev;
						end
					end
					if (idx_q == (AW+1)'(SLOTS)) begin
						rsp_q <= rsp_n;
						if (rq.req_type == gst_pkg::REQ_ABANDON || cmd_q.early_fail) begin
							st_q <= ST_DONE;
						end else if (match_q || (used_q[prev] && r_key == rq.seg_key)) begin
							st_q <= ST_RD;
						end else if (we) begin
							st_q <= ST_DONE;
							ngen_q <= ngen_q + 32'd1;
							if (rq.alloc_ok) used_q[free_q] <= 1'b1;
						end else if (free_v_q || used_q[prev] || cmd_q.pages == '0) begin
							st_q <= ST_DONE;
						end
						// otherwise stay in the scan state so the last slot's free flag lands
					end else idx_q <= idx_q + (AW+1)'(1);
				end
				ST_RD: st_q <= ST_CHK;
				ST_CHK: begin
					st_q <= ST_DONE;
					rsp_q <= rsp_n;
					if (rq.req_type == gst_pkg::REQ_DESTROY && rsp_n.success)
						used_q[hslot] <= 1'b0;
				end
				ST_DONE: begin ov_q <= 1'b1; st_q <= ST_IDLE; end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/generational_segment_table.sv =====
// Generational segment table.
// Channels: req (gst_req_if sink) carries one request per transfer;
// rsp (gst_rsp_if source) returns exactly one result per request, in order.
// cfg_we/cfg_wdata write public_mask (reset 1); write only while idle.
// A two-entry queue sits between the front (page count, key check) and the
// back (slot table in a RAM, used bits in flops).
// Open and abandon scan every slot, one per cycle, through the RAM read
// port, and stay in the scan state until the last slot's free flag lands
// when that slot is the only free one; an open that hits an existing key
// then reads that slot again. Destroy and query read one slot. One request
// is in the back at a time and the next starts the cycle after the result
// transfers, so the back takes no new request until the last result has
// transferred.
// Reset clears all used bits and sets the generation counter to 1; slot
// contents need no clearing since unused slots are never trusted.
// If rsp is stalled the result holds in the output register, the back
// waits, and the queue keeps taking up to two more requests.
module generational_segment_table #(
	parameter int SLOTS = gst_pkg::SLOTS_DEF,
	parameter int SLOT_BITS = gst_pkg::SLOT_BITS_DEF,
	parameter int PAGE_BYTES = gst_pkg::PAGE_BYTES_DEF,
	parameter int MAX_PAGES = gst_pkg::MAX_PAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [31:0] cfg_wdata,
	gst_req_if.sink req,
	gst_rsp_if.source rsp
);
	logic [31:0] mask_q;
	logic q_valid, q_ready;
	gst_pkg::cmd_t q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mask_q <= gst_pkg::PUBLIC_RESET;
		else if (cfg_we) mask_q <= cfg_wdata;
	end

	gst_front #(.PAGE_BYTES(PAGE_BYTES), .MAX_PAGES(MAX_PAGES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(req),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));
	gst_back #(.SLOTS(SLOTS), .SLOT_BITS(SLOT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .public_mask(mask_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd), .out_ch(rsp));
endmodule

// ===== hw/rtl/gst_checker.sv =====
`include "generational_segment_table_assert.svh"
module gst_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input gst_pkg::rsp_t rsp_payload
);
	`GST_ASSERT(a_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
	`GST_ASSERT(a_fail_h, clk, arst_n, rsp_valid && !rsp_payload.success |-> rsp_payload.handle_out == -32'sd1, "fail handle")
	`GST_ASSERT(a_excl, clk, arst_n, rsp_valid && rsp_payload.freed_count != 6'd0 |-> rsp_payload.handle_out == -32'sd1 && !rsp_payload.may_access, "field mix")
	`GST_ASSERT_NR(a_rst, clk, !arst_n |=> !rsp_valid, "valid in reset")
endmodule

bind generational_segment_table gst_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload));
